### rtl/core/pma_pkg.sv
// Shared types and constants for the dense minimum spanning tree block.
`timescale 1ns / 1ps
package pma_pkg;

  // Graph size and field widths
  localparam int MAX_V       = 64;
  localparam int IDX_W       = $clog2(MAX_V);
  localparam int CNT_W       = $clog2(MAX_V + 1);
  localparam int WEIGHT_BITS = 10;
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int TOTAL_W     = 16;

  // Length that stands for "not reached"
  localparam logic [WEIGHT_BITS-1:0] INF_LEN = WEIGHT_BITS'(1000);

  // Per-vertex state carried around the cell ring
  typedef struct packed {
    logic                   in_tree;
    logic                   has_par;
    logic [IDX_W-1:0]       par;
    logic [WEIGHT_BITS-1:0] best;
  } vtx_t;

endpackage

### rtl/core/pma_cell.sv
// One ring cell: holds one vertex's tree state and passes it on when the ring turns.
`timescale 1ns / 1ps
module pma_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  pma_pkg::vtx_t d_in,
  output pma_pkg::vtx_t q
);

  pma_pkg::vtx_t q_r;

  // Take the neighbor's word on each ring step
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

### rtl/core/pma_head.sv
// Ring head: relaxes one vertex against the current row and flags a new minimum.
`timescale 1ns / 1ps
module pma_head (
  input  pma_pkg::vtx_t                      cur,
  input  logic [pma_pkg::WEIGHT_BITS-1:0]    weight,
  input  logic [pma_pkg::IDX_W-1:0]          idx,
  input  logic [pma_pkg::IDX_W-1:0]          cur_vtx,
  input  logic                               init,
  input  logic                               scan_en,
  input  logic                               active,
  input  logic [pma_pkg::WEIGHT_BITS-1:0]    min_len,
  output pma_pkg::vtx_t                      nxt,
  output logic                               take
);

  pma_pkg::vtx_t base;
  pma_pkg::vtx_t relaxed;
  logic          is_cur;
  logic          it;
  logic          upd;

  always_comb begin
    is_cur = (idx == cur_vtx);
    // Start from fresh state on the first pass of a run; the root gets length zero
    if (init) begin
      base.in_tree = 1'b0;
      base.has_par = 1'b0;
      base.par     = '0;
      base.best    = is_cur ? '0 : pma_pkg::INF_LEN;
    end else begin
      base = cur;
    end
    // The vertex whose row is scanned joins the tree now
    it  = base.in_tree | is_cur;
    upd = !it && (weight != '0) && (weight < base.best);

    relaxed         = base;
    relaxed.in_tree = it;
    if (upd) begin
      relaxed.best    = weight;
      relaxed.has_par = 1'b1;
      relaxed.par     = cur_vtx;
    end

    // Pass the word through untouched outside the scan
    nxt  = scan_en ? relaxed : cur;
    take = scan_en && active && !it && (relaxed.best < min_len);
  end

endmodule

### rtl/core/prim_mst_adjacency_matrix.sv
// Top level: matrix store, ring of vertex cells, search control, result and APB ports.
// Flow: each matrix word is written into the store as it is taken. After the last word, every tree
// step is one scan of the cell ring (a read prime in ST_PRIME, a full ring turn in ST_SCAN,
// then ST_PICK), repeated once per vertex reached; a further turn in ST_DUMP, held by out_ready, emits the results.
// Throughput: one word per cycle while loading; no new word during search and dump.
// Reset: rst_n is synchronous; it idles control and sets config to 64 vertices from 0.
`timescale 1ns / 1ps
module prim_mst_adjacency_matrix (
  input  logic                               clk,
  input  logic                               rst_n,
  // matrix word input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pma_pkg::IDX_W-1:0]          in_row,
  input  logic [pma_pkg::IDX_W-1:0]          in_col,
  input  logic [pma_pkg::WEIGHT_BITS-1:0]    in_edge_weight,
  input  logic                               in_last_entry,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pma_pkg::IDX_W-1:0]          out_vertex,
  output logic                               out_has_parent,
  output logic [pma_pkg::IDX_W-1:0]          out_parent,
  output logic [pma_pkg::WEIGHT_BITS-1:0]    out_edge_length,
  output logic [pma_pkg::TOTAL_W-1:0]        out_total_length,
  output logic                               out_last_result,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_START  = 1'b1;

  typedef enum logic [2:0] {ST_IDLE, ST_PRIME, ST_SCAN, ST_PICK, ST_DUMP} state_t;

  state_t                              state_r;
  logic [pma_pkg::CNT_W-1:0]           vcount_r;
  logic [pma_pkg::IDX_W-1:0]           start_r;
  logic [pma_pkg::CNT_W-1:0]           n_r;
  logic [pma_pkg::IDX_W-1:0]           k_r;
  logic                                first_r;
  logic [pma_pkg::IDX_W-1:0]           head_idx_r;
  logic [pma_pkg::WEIGHT_BITS-1:0]     min_r;
  logic [pma_pkg::IDX_W-1:0]           pick_r;
  logic                                found_r;
  logic [pma_pkg::TOTAL_W-1:0]         sum_r;
  logic                                out_valid_r;
  logic [pma_pkg::IDX_W-1:0]           out_vertex_r;
  logic                                out_has_parent_r;
  logic [pma_pkg::IDX_W-1:0]           out_parent_r;
  logic [pma_pkg::WEIGHT_BITS-1:0]     out_edge_length_r;
  logic [pma_pkg::TOTAL_W-1:0]         out_total_length_r;
  logic                                out_last_result_r;

  logic [pma_pkg::WEIGHT_BITS-1:0]     mem_r [pma_pkg::MAX_V * pma_pkg::MAX_V];
  logic [pma_pkg::WEIGHT_BITS-1:0]     mem_q_r;
  logic [pma_pkg::ADDR_W-1:0]          rd_addr;

  logic [pma_pkg::CNT_W-1:0]           n_nxt;
  logic [pma_pkg::IDX_W-1:0]           root_nxt;
  logic                                in_fire;
  logic                                cfg_wr;
  logic                                out_ok;
  logic                                rot;
  logic                                scan_en;
  logic                                active;
  logic                                last_step;
  logic                                emit_last;
  logic                                emit;
  logic                                take;

  pma_pkg::vtx_t                       ring_q [pma_pkg::MAX_V];
  pma_pkg::vtx_t                       head_nxt;
  pma_pkg::vtx_t                       head_cur;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign out_ok    = !out_valid_r || out_ready;
  assign scan_en   = (state_r == ST_SCAN);
  assign rot       = scan_en || ((state_r == ST_DUMP) && out_ok);
  assign head_cur  = ring_q[pma_pkg::MAX_V-1];
  assign active    = ({1'b0, head_idx_r} < n_r);
  assign last_step = (head_idx_r == pma_pkg::IDX_W'(pma_pkg::MAX_V - 1));
  assign emit_last = ({1'b0, head_idx_r} == (n_r - pma_pkg::CNT_W'(1)));
  assign emit      = (state_r == ST_DUMP) && out_ok && active;

  // Clamp vertex count and root for the run about to start
  always_comb begin
    n_nxt = vcount_r;
    if (vcount_r == '0) begin
      n_nxt = pma_pkg::CNT_W'(1);
    end else if (vcount_r > pma_pkg::CNT_W'(pma_pkg::MAX_V)) begin
      n_nxt = pma_pkg::CNT_W'(pma_pkg::MAX_V);
    end
    if ({1'b0, start_r} >= n_nxt) begin
      root_nxt = pma_pkg::IDX_W'(n_nxt - pma_pkg::CNT_W'(1));
    end else begin
      root_nxt = start_r;
    end
  end

  // Read one word ahead of the ring head
  assign rd_addr = {k_r, head_idx_r + pma_pkg::IDX_W'(rot)};

  // Matrix store: written by incoming words, read one row word per cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_r[{in_row, in_col}] <= in_edge_weight;
    end
    mem_q_r <= mem_r[rd_addr];
  end

  // Ring head
  pma_head u_head (
    .cur     (head_cur),
    .weight  (mem_q_r),
    .idx     (head_idx_r),
    .cur_vtx (k_r),
    .init    (first_r),
    .scan_en (scan_en),
    .active  (active),
    .min_len (min_r),
    .nxt     (head_nxt),
    .take    (take)
  );

  // Ring of vertex cells; the head feeds cell zero
  for (genvar j = 0; j < pma_pkg::MAX_V; j++) begin : g_ring
    if (j == 0) begin : g_first
      pma_cell u_cell (
        .clk      (clk),
        .shift_en (rot),
        .d_in     (head_nxt),
        .q        (ring_q[j])
      );
    end else begin : g_rest
      pma_cell u_cell (
        .clk      (clk),
        .shift_en (rot),
        .d_in     (ring_q[j-1]),
        .q        (ring_q[j])
      );
    end
  end

  // Search control, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= pma_pkg::CNT_W'(64);
      start_r     <= '0;
      n_r         <= pma_pkg::CNT_W'(1);
      k_r         <= '0;
      first_r     <= 1'b0;
      head_idx_r  <= '0;
      min_r       <= pma_pkg::INF_LEN;
      pick_r      <= '0;
      found_r     <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Write configuration
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_VCOUNT: vcount_r <= cfg_pwdata[pma_pkg::CNT_W-1:0];
          REG_START:  start_r  <= cfg_pwdata[pma_pkg::IDX_W-1:0];
          default:    ;
        endcase
      end

      // Drop a word that was taken unless a new one replaces it
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end

      // Advance the head index with the ring
      if (rot) begin
        head_idx_r <= head_idx_r + pma_pkg::IDX_W'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && in_last_entry) begin
            n_r     <= n_nxt;
            k_r     <= root_nxt;
            first_r <= 1'b1;
            state_r <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          min_r   <= pma_pkg::INF_LEN;
          found_r <= 1'b0;
          pick_r  <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (take) begin
            min_r   <= head_nxt.best;
            pick_r  <= head_idx_r;
            found_r <= 1'b1;
          end
          if (last_step) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          first_r <= 1'b0;
          if (found_r) begin
            k_r     <= pick_r;
            state_r <= ST_PRIME;
          end else begin
            sum_r   <= '0;
            state_r <= ST_DUMP;
          end
        end
        ST_DUMP: begin
          if (out_ok) begin
            if (active) begin
              out_valid_r        <= 1'b1;
              out_vertex_r       <= head_idx_r;
              out_has_parent_r   <= head_cur.has_par;
              out_parent_r       <= head_cur.has_par ? head_cur.par : '0;
              out_edge_length_r  <= head_cur.best;
              out_last_result_r  <= emit_last;
              out_total_length_r <= emit_last ?
                                    sum_r + pma_pkg::TOTAL_W'(head_cur.best) : '0;
              sum_r              <= sum_r + pma_pkg::TOTAL_W'(head_cur.best);
            end
            if (last_step) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Register readback
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      REG_VCOUNT: cfg_prdata = 32'(vcount_r);
      REG_START:  cfg_prdata = 32'(start_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg_pready       = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_vertex       = out_vertex_r;
  assign out_has_parent   = out_has_parent_r;
  assign out_parent       = out_parent_r;
  assign out_edge_length  = out_edge_length_r;
  assign out_total_length = out_total_length_r;
  assign out_last_result  = out_last_result_r;

endmodule
